// ===== rtl/wvc_pkg.sv =====
// Shared constants, types and the arctangent table of the waypoint to velocity converter.
`default_nettype none
package wvc_pkg;

   // Vectoring step count, valid range 8 to 24
   localparam int CORDIC_STEPS   = 16;
   localparam int ATAN_TABLE_LEN = 24;
   localparam int STEP_W         = $clog2(CORDIC_STEPS);

   // Coordinate and datapath widths
   localparam int POS_W   = 16;            // Q3.12 waypoint coordinate
   localparam int DELTA_W = POS_W + 1;     // coordinate difference
   localparam int HEAD_W  = 16;            // heading, Q4.12, unsigned
   localparam int CORD_XW = 36;            // CORDIC x/y, scaled by 2^16 plus gain
   localparam int CORD_ZW = 35;            // CORDIC angle, Q.30
   localparam int MUL_W   = 18;            // shared multiplier operand
   localparam int PROD_W  = 2 * MUL_W;
   localparam int SQ_IN_W = 34;            // dx^2 + dy^2
   localparam int SQ_ROOT_W = SQ_IN_W / 2;
   localparam int SQ_W    = SQ_IN_W + 1;   // root/remainder working width
   localparam int INV_W   = 16;
   localparam int SH_W    = 15;
   localparam int LIN_W   = 31;
   localparam int ANG_W   = 32;

   // Angle constants
   localparam logic signed [DELTA_W-1:0] PI_Q12     = 17'sd12868;
   localparam logic signed [DELTA_W-1:0] TWO_PI_Q12 = 17'sd25736;
   localparam logic signed [CORD_ZW-1:0] PI_Q30     = 35'sd3373259426;
   localparam logic signed [CORD_ZW-1:0] ROUND_HALF = 35'sd131072;

   // Configuration register indexes
   localparam logic CSR_INV_TIME_STEP = 1'b0;
   localparam logic CSR_START_HEADING = 1'b1;

   // Sequencer states
   typedef enum logic [8:0] {
      ST_IDLE   = 9'b000000001,
      ST_SQX    = 9'b000000010,
      ST_SQY    = 9'b000000100,
      ST_SUM    = 9'b000001000,
      ST_ITER   = 9'b000010000,
      ST_FOLD   = 9'b000100000,
      ST_LIN    = 9'b001000000,
      ST_ANG    = 9'b010000000,
      ST_RESULT = 9'b100000000
   } state_type;

   // Start / status pair of an iterative unit
   typedef struct packed {
      logic start;
   } unit_ctrl_type;

   typedef struct packed {
      logic busy;
   } unit_stat_type;

   // atan(2^-i) in Q.30
   function automatic logic signed [CORD_ZW-1:0] atan_q30(input logic [4:0] idx);
      logic signed [CORD_ZW-1:0] v;
      case (idx)
         5'd0:  v = 35'sd843314857;
         5'd1:  v = 35'sd497837829;
         5'd2:  v = 35'sd263043836;
         5'd3:  v = 35'sd133525158;
         5'd4:  v = 35'sd67021686;
         5'd5:  v = 35'sd33543515;
         5'd6:  v = 35'sd16775850;
         5'd7:  v = 35'sd8388437;
         5'd8:  v = 35'sd4194282;
         5'd9:  v = 35'sd2097149;
         5'd10: v = 35'sd1048575;
         5'd11: v = 35'sd524287;
         5'd12: v = 35'sd262143;
         5'd13: v = 35'sd131071;
         5'd14: v = 35'sd65535;
         5'd15: v = 35'sd32767;
         5'd16: v = 35'sd16383;
         5'd17: v = 35'sd8191;
         5'd18: v = 35'sd4095;
         5'd19: v = 35'sd2047;
         5'd20: v = 35'sd1023;
         5'd21: v = 35'sd511;
         5'd22: v = 35'sd255;
         5'd23: v = 35'sd127;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage
`default_nettype wire

// ===== rtl/waypoint_to_velocity_converter.sv =====
// Top level: waypoint store, sequencer, shared multiplier, square root and CORDIC units.
// A path-start point is taken and gives no result; any other point runs through ST_SQX,
// ST_SQY, ST_SUM, ST_ITER (until the 17-step square root and the CORDIC are done),
// ST_FOLD, ST_LIN, ST_ANG, ST_RESULT; req_ready is high only while the sequencer idles.
// The result waits in an output register, so the next point is taken while it is pending.
// Reset: synchronous; clears the path, loads inv_time_step 5120 and start_heading 6434.
`default_nettype none
module waypoint_to_velocity_converter (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_valid,
   output logic                                     req_ready,
   input  wire logic signed [wvc_pkg::POS_W-1:0]    req_x_pos,
   input  wire logic signed [wvc_pkg::POS_W-1:0]    req_y_pos,
   input  wire logic                                req_start_path,
   output logic                                     rsp_valid,
   input  wire logic                                rsp_ready,
   output logic [wvc_pkg::LIN_W-1:0]                rsp_lin_vel,
   output logic signed [wvc_pkg::ANG_W-1:0]         rsp_ang_vel,
   input  wire logic                                csr_wr_en,
   input  wire logic                                csr_index,
   input  wire logic [wvc_pkg::INV_W-1:0]           csr_wdata
);

   wvc_pkg::state_type state_ff, state_in;

   logic [wvc_pkg::INV_W-1:0]               inv_ff;
   logic [wvc_pkg::SH_W-1:0]                start_heading_ff;
   logic                                    have_point_ff;
   logic signed [wvc_pkg::POS_W-1:0]        last_x_ff, last_y_ff;
   logic [wvc_pkg::HEAD_W-1:0]              last_heading_ff;
   logic signed [wvc_pkg::DELTA_W-1:0]      dx_ff, dy_ff, dx_in, dy_in;
   logic [wvc_pkg::SQ_IN_W-1:0]             sq_acc_ff, sq_sum;
   logic [wvc_pkg::HEAD_W-1:0]              head_ff;
   logic signed [wvc_pkg::DELTA_W-1:0]      dw_ff, dw_raw, dw_in;
   logic [wvc_pkg::LIN_W-1:0]               lin_ff;
   logic                                    rsp_valid_ff, rsp_valid_in;
   logic [wvc_pkg::LIN_W-1:0]               rsp_lin_ff;
   logic signed [wvc_pkg::ANG_W-1:0]        rsp_ang_ff;

   logic                                    accept, path_start, rsp_load;
   logic                                    mul_en;
   logic signed [wvc_pkg::MUL_W-1:0]        mul_a, mul_b;
   logic signed [wvc_pkg::PROD_W-1:0]       prod;
   wvc_pkg::unit_ctrl_type                  unit_ctrl;
   wvc_pkg::unit_stat_type                  sq_stat, cd_stat;
   logic [wvc_pkg::SQ_ROOT_W-1:0]           seg_len;
   logic signed [wvc_pkg::CORD_ZW-1:0]      cd_angle, z_round;
   logic signed [wvc_pkg::DELTA_W-1:0]      head_raw, head_fold;

   assign req_ready  = (state_ff == wvc_pkg::ST_IDLE);
   assign accept     = req_valid && req_ready;
   assign path_start = req_start_path || !have_point_ff;
   assign rsp_load   = (state_ff == wvc_pkg::ST_RESULT) && (!rsp_valid_ff || rsp_ready);

   // Sequencer
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         wvc_pkg::ST_IDLE:   if (accept && !path_start) state_in = wvc_pkg::ST_SQX;
         wvc_pkg::ST_SQX:    state_in = wvc_pkg::ST_SQY;
         wvc_pkg::ST_SQY:    state_in = wvc_pkg::ST_SUM;
         wvc_pkg::ST_SUM:    state_in = wvc_pkg::ST_ITER;
         wvc_pkg::ST_ITER:   if (!sq_stat.busy && !cd_stat.busy) state_in = wvc_pkg::ST_FOLD;
         wvc_pkg::ST_FOLD:   state_in = wvc_pkg::ST_LIN;
         wvc_pkg::ST_LIN:    state_in = wvc_pkg::ST_ANG;
         wvc_pkg::ST_ANG:    state_in = wvc_pkg::ST_RESULT;
         wvc_pkg::ST_RESULT: if (rsp_load) state_in = wvc_pkg::ST_IDLE;
         default:            state_in = wvc_pkg::ST_IDLE;
      endcase
   end

   // Control registers and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= wvc_pkg::ST_IDLE;
         have_point_ff    <= 1'b0;
         rsp_valid_ff     <= 1'b0;
         inv_ff           <= 16'd5120;
         start_heading_ff <= 15'd6434;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            have_point_ff <= 1'b1;
         end
         if (csr_wr_en) begin
            case (csr_index)
               wvc_pkg::CSR_INV_TIME_STEP: inv_ff <= csr_wdata;
               wvc_pkg::CSR_START_HEADING: start_heading_ff <= csr_wdata[wvc_pkg::SH_W-1:0];
               default: ;
            endcase
         end
      end
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_ready ? 1'b0 : rsp_valid_ff);

   // Segment delta against the stored point
   assign dx_in = {req_x_pos[wvc_pkg::POS_W-1], req_x_pos}
                - {last_x_ff[wvc_pkg::POS_W-1], last_x_ff};
   assign dy_in = {req_y_pos[wvc_pkg::POS_W-1], req_y_pos}
                - {last_y_ff[wvc_pkg::POS_W-1], last_y_ff};

   // Heading: round Q.30 to Q3.12, fold negatives into [0, 2pi)
   assign z_round   = (cd_angle + wvc_pkg::ROUND_HALF) >>> 18;
   assign head_raw  = z_round[wvc_pkg::DELTA_W-1:0];
   assign head_fold = (head_raw < 0) ? head_raw + wvc_pkg::TWO_PI_Q12 : head_raw;

   // Heading change wrapped into [-pi, pi]
   assign dw_raw = {1'b0, head_ff} - {1'b0, last_heading_ff};
   always_comb begin
      dw_in = dw_raw;
      if (dw_raw > wvc_pkg::PI_Q12) begin
         dw_in = dw_raw - wvc_pkg::TWO_PI_Q12;
      end else if (dw_raw < -wvc_pkg::PI_Q12) begin
         dw_in = dw_raw + wvc_pkg::TWO_PI_Q12;
      end
   end

   assign sq_sum = sq_acc_ff + prod[wvc_pkg::SQ_IN_W-1:0];

   // Datapath registers
   always_ff @(posedge clock) begin
      if (accept) begin
         last_x_ff <= req_x_pos;
         last_y_ff <= req_y_pos;
         dx_ff     <= dx_in;
         dy_ff     <= dy_in;
         if (path_start) begin
            last_heading_ff <= {1'b0, start_heading_ff};
         end
      end
      if (state_ff == wvc_pkg::ST_SQY) begin
         sq_acc_ff <= prod[wvc_pkg::SQ_IN_W-1:0];
      end
      if (state_ff == wvc_pkg::ST_FOLD) begin
         head_ff <= head_fold[wvc_pkg::HEAD_W-1:0];
      end
      if (state_ff == wvc_pkg::ST_LIN) begin
         dw_ff           <= dw_in;
         last_heading_ff <= head_ff;
      end
      if (state_ff == wvc_pkg::ST_ANG) begin
         lin_ff <= {{(wvc_pkg::LIN_W - wvc_pkg::PROD_W + 8){1'b0}},
                    prod[wvc_pkg::PROD_W-1:8]};
      end
      if (rsp_load) begin
         rsp_lin_ff <= lin_ff;
         rsp_ang_ff <= {{(wvc_pkg::ANG_W - wvc_pkg::PROD_W + 8){prod[wvc_pkg::PROD_W-1]}},
                        prod[wvc_pkg::PROD_W-1:8]};
      end
   end

   // Shared multiplier operand select
   always_comb begin
      mul_en = 1'b1;
      mul_a  = '0;
      mul_b  = '0;
      case (state_ff)
         wvc_pkg::ST_SQX: begin
            mul_a = {dx_ff[wvc_pkg::DELTA_W-1], dx_ff};
            mul_b = {dx_ff[wvc_pkg::DELTA_W-1], dx_ff};
         end
         wvc_pkg::ST_SQY: begin
            mul_a = {dy_ff[wvc_pkg::DELTA_W-1], dy_ff};
            mul_b = {dy_ff[wvc_pkg::DELTA_W-1], dy_ff};
         end
         wvc_pkg::ST_LIN: begin
            mul_a = {1'b0, seg_len};
            mul_b = {2'b0, inv_ff};
         end
         wvc_pkg::ST_ANG: begin
            mul_a = {dw_ff[wvc_pkg::DELTA_W-1], dw_ff};
            mul_b = {2'b0, inv_ff};
         end
         default: mul_en = 1'b0;
      endcase
   end

   assign unit_ctrl.start = (state_ff == wvc_pkg::ST_SUM);

   wvc_mul u_mul (
      .clock   (clock),
      .enable  (mul_en),
      .op_a    (mul_a),
      .op_b    (mul_b),
      .prod_ff (prod)
   );

   wvc_sqrt u_sqrt (
      .clock   (clock),
      .reset   (reset),
      .ctrl    (unit_ctrl),
      .operand (sq_sum),
      .stat    (sq_stat),
      .root    (seg_len)
   );

   wvc_cordic u_cordic (
      .clock (clock),
      .reset (reset),
      .ctrl  (unit_ctrl),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .stat  (cd_stat),
      .angle (cd_angle)
   );

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_lin_vel = rsp_lin_ff;
   assign rsp_ang_vel = rsp_ang_ff;

endmodule
`default_nettype wire

// ===== rtl/wvc_mul.sv =====
// Shared signed multiplier with registered product.
`default_nettype none
module wvc_mul (
   input  wire logic                                clock,
   input  wire logic                                enable,
   input  wire logic signed [wvc_pkg::MUL_W-1:0]    op_a,
   input  wire logic signed [wvc_pkg::MUL_W-1:0]    op_b,
   output logic signed [wvc_pkg::PROD_W-1:0]        prod_ff
);

   // Product holds while idle so a result can wait in it
   always_ff @(posedge clock) begin
      if (enable) begin
         prod_ff <= op_a * op_b;
      end
   end

endmodule
`default_nettype wire

// ===== rtl/wvc_sqrt.sv =====
// Bit-serial integer square root, one result bit per cycle.
`default_nettype none
module wvc_sqrt (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire wvc_pkg::unit_ctrl_type             ctrl,
   input  wire logic [wvc_pkg::SQ_IN_W-1:0]        operand,
   output wvc_pkg::unit_stat_type                  stat,
   output logic [wvc_pkg::SQ_ROOT_W-1:0]           root
);

   localparam int TOP_BIT = 2 * (wvc_pkg::SQ_ROOT_W - 1);

   logic [wvc_pkg::SQ_W-1:0] rem_ff;
   logic [wvc_pkg::SQ_W-1:0] root_ff;
   logic [wvc_pkg::SQ_W-1:0] bit_ff;
   logic                     busy_ff;
   logic [wvc_pkg::SQ_W-1:0] trial;

   assign trial = root_ff + bit_ff;

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && bit_ff[0]) begin
         busy_ff <= 1'b0;
      end
   end

   // Restoring step
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         rem_ff  <= {1'b0, operand};
         root_ff <= '0;
         bit_ff  <= wvc_pkg::SQ_W'(1) << TOP_BIT;
      end else if (busy_ff) begin
         if (rem_ff >= trial) begin
            rem_ff  <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
      end
   end

   assign stat.busy = busy_ff;
   assign root      = root_ff[wvc_pkg::SQ_ROOT_W-1:0];

endmodule
`default_nettype wire

// ===== rtl/wvc_cordic.sv =====
// Iterative CORDIC vectoring unit, one micro-rotation per cycle.
`default_nettype none
module wvc_cordic (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire wvc_pkg::unit_ctrl_type                 ctrl,
   input  wire logic signed [wvc_pkg::DELTA_W-1:0]     dx,
   input  wire logic signed [wvc_pkg::DELTA_W-1:0]     dy,
   output wvc_pkg::unit_stat_type                      stat,
   output logic signed [wvc_pkg::CORD_ZW-1:0]          angle
);

   localparam int PAD_W = wvc_pkg::CORD_XW - wvc_pkg::DELTA_W - 16;

   logic signed [wvc_pkg::CORD_XW-1:0] x_ff, y_ff, xs, ys, x_ld, y_ld;
   logic signed [wvc_pkg::CORD_ZW-1:0] z_ff, z_ld, step_atan;
   logic [wvc_pkg::STEP_W-1:0]         step_ff;
   logic                               busy_ff;
   logic                               last_step;

   // Scale by 2^16, mirror left half-plane into the right one
   always_comb begin
      x_ld = {{PAD_W{dx[wvc_pkg::DELTA_W-1]}}, dx, 16'b0};
      y_ld = {{PAD_W{dy[wvc_pkg::DELTA_W-1]}}, dy, 16'b0};
      z_ld = '0;
      if (dx < 0) begin
         x_ld = -x_ld;
         y_ld = -y_ld;
         z_ld = (dy >= 0) ? wvc_pkg::PI_Q30 : -wvc_pkg::PI_Q30;
      end
   end

   assign xs        = x_ff >>> step_ff;
   assign ys        = y_ff >>> step_ff;
   assign step_atan = wvc_pkg::atan_q30(5'(step_ff));
   assign last_step = (step_ff == wvc_pkg::STEP_W'(wvc_pkg::CORDIC_STEPS - 1));

   // Control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (ctrl.start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && last_step) begin
         busy_ff <= 1'b0;
      end
   end

   // Micro-rotation; a zero residual leaves x, y and z as they are
   always_ff @(posedge clock) begin
      if (ctrl.start) begin
         x_ff    <= x_ld;
         y_ff    <= y_ld;
         z_ff    <= z_ld;
         step_ff <= '0;
      end else if (busy_ff) begin
         if (y_ff > 0) begin
            x_ff <= x_ff + ys;
            y_ff <= y_ff - xs;
            z_ff <= z_ff + step_atan;
         end else if (y_ff < 0) begin
            x_ff <= x_ff - ys;
            y_ff <= y_ff + xs;
            z_ff <= z_ff - step_atan;
         end
         step_ff <= step_ff + 1'b1;
      end
   end

   assign stat.busy = busy_ff;
   assign angle     = z_ff;

endmodule
`default_nettype wire
